@@ rtl/bb3_pkg.sv @@
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Pixel and window types, register and opcode codes, and the reciprocal
// table used to turn the rounded mean into a multiply and shift.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int LINE_CFG_W  = 11;
	localparam int ROWS_CFG_W  = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;

	localparam logic [LINE_CFG_W-1:0] LINE_WIDTH_RST   = 11'd640;
	localparam logic [ROWS_CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// channel sum of up to nine 8-bit values, and 2*sum + count
	localparam int SUM_W       = 12;
	localparam int DIV_X_W     = 13;
	localparam int RECIP_W     = 14;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = DIV_X_W + RECIP_W;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LINE_WIDTH   = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// [row][col], row 0 on top, col 0 on the left
	typedef rgb_t [2:0][2:0] win_t;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
	} avg_mask_t;

	// 2^16 / (2 * count), rounded up; exact over the reachable sums
	function automatic logic [RECIP_W-1:0] recip(input logic full_rows, input logic full_cols);
		logic [RECIP_W-1:0] r;
		case ({full_rows, full_cols})
			2'b11:   r = 14'd3641;
			2'b10:   r = 14'd5462;
			2'b01:   r = 14'd5462;
			default: r = 14'd8192;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] pix_count(input logic full_rows, input logic full_cols);
		logic [3:0] n;
		case ({full_rows, full_cols})
			2'b11:   n = 4'd9;
			2'b10:   n = 4'd6;
			2'b01:   n = 4'd6;
			default: n = 4'd4;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/bb3_avg.sv @@
// ----------------------------------------------------------------------------
// bb3_avg: rounded neighbourhood mean
// Sums the masked pixels of a 3x3 window per channel and divides
// (2*sum + n) by 2n through a reciprocal multiply, n being 4, 6 or 9.
// ----------------------------------------------------------------------------
module bb3_avg import bb3_pkg::*; (
	input  win_t      win,
	input  avg_mask_t mask,
	output rgb_t      mean
);

	logic [9:0]         row_sum [3][3];
	logic [SUM_W-1:0]   sum     [3];
	logic [DIV_X_W-1:0] xval    [3];
	logic [PROD_W-1:0]  prod    [3];
	logic               full_rows;
	logic               full_cols;
	logic [RECIP_W-1:0] rcp;
	logic [3:0]         cnt;

	always_comb begin
		// a window always has two or three rows and two or three columns in frame
		full_rows = &mask.row;
		full_cols = &mask.col;
		rcp       = recip(full_rows, full_cols);
		cnt       = pix_count(full_rows, full_cols);
		mean      = '0;
		for (int k = 0; k < 3; k++) begin
			sum[k] = '0;
			for (int i = 0; i < 3; i++) begin
				row_sum[k][i] = '0;
				for (int j = 0; j < 3; j++) begin
					if (mask.row[i] && mask.col[j]) begin
						row_sum[k][i] = row_sum[k][i] + 10'(win[i][j][8*k +: 8]);
					end
				end
				sum[k] = sum[k] + SUM_W'(row_sum[k][i]);
			end
			xval[k] = {sum[k], 1'b0} + DIV_X_W'(cnt);
			prod[k] = PROD_W'(xval[k]) * PROD_W'(rcp);
			mean[8*k +: 8] = prod[k][RECIP_SHIFT +: 8];
		end
	end

endmodule

@@ rtl/box_blur_3x3_edge_aware_unit.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_unit: 3x3 box blur over a raster RGB stream
// Takes one item per clock and returns one result per clock unless the output
// stalls. Each result is the per-channel mean of the in-frame pixels around a
// pixel, rounded half up, and trails the input by one row plus one pixel; after
// the last pixel of a frame, one flush item per pixel of the last row drains
// that row. The last pixel of a frame gives two results, so it holds the input
// back: a single averaging unit feeds the output register one result per cycle.
// Two line buffers of MAX_LINE entries, each with two read ports and registered
// read data, need no clearing pass after reset; an entry read before it was
// written only reaches masked pixels. A register write restarts the frame.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_unit import bb3_pkg::*; #(
	parameter int MAX_LINE = 1024,
	parameter int MAX_ROWS = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   opcode,
	input  logic [7:0]             in_red,
	input  logic [7:0]             in_green,
	input  logic [7:0]             in_blue,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_red,
	output logic [7:0]             out_green,
	output logic [7:0]             out_blue,
	output logic                   frame_end
);

	localparam int COL_W = $clog2(MAX_LINE);
	localparam int WID_W = $clog2(MAX_LINE + 1);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int HGT_W = $clog2(MAX_ROWS + 1);

	typedef enum logic [1:0] {
		KIND_EDGE_OLD,
		KIND_MID,
		KIND_EDGE_NEW,
		KIND_FLUSH
	} kind_t;

	typedef struct packed {
		logic       is_flush;
		logic [1:0] res_cnt;
		kind_t      kind0;
		logic       top0;
		logic       left0;
		logic       right0;
		logic       last0;
		logic       top_new;
	} s1_ctl_t;

	// configuration and position
	logic [LINE_CFG_W-1:0] lw_q;
	logic [ROWS_CFG_W-1:0] fh_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [COL_W-1:0]      fcnt_q;
	logic                  pend_q;
	logic [WID_W-1:0]      eff_w;
	logic [HGT_W-1:0]      eff_h;

	// accept side
	logic             in_fire;
	logic             is_flush;
	logic             wrap;
	logic [COL_W-1:0] c0;
	logic [ROW_W-1:0] r0;
	logic             col_last;
	logic             row_last;
	logic             fl_ok;
	logic             fl_last;
	logic [COL_W-1:0] addr_a;
	logic [COL_W-1:0] addr_b;
	logic             fwd_a;
	logic             fwd_b;
	logic             load_s1;
	s1_ctl_t          ctl0;

	// item register
	logic             s1_valid_q;
	s1_ctl_t          s1_q;
	logic [COL_W-1:0] c_s1;
	rgb_t             pix_s1;
	rgb_t             top_a_s1;
	rgb_t             mid_a_s1;
	rgb_t             top_b_s1;
	rgb_t             mid_b_s1;
	logic             slot_q;

	// line buffers, window and flush columns
	rgb_t older_mem [MAX_LINE];
	rgb_t newer_mem [MAX_LINE];
	win_t win_q;
	win_t nxt_win;
	rgb_t fl_top_q;
	rgb_t fl_mid_q;
	logic mem_we;

	// result side
	logic      out_space;
	logic      last_slot;
	logic      emit;
	logic      s1_done;
	kind_t     cur_kind;
	win_t      avg_win;
	avg_mask_t avg_mask;
	rgb_t      mean;
	logic      res_end;

	always_comb begin
		if (lw_q < LINE_CFG_W'(2)) begin
			eff_w = WID_W'(2);
		end else if (32'(lw_q) > MAX_LINE) begin
			eff_w = WID_W'(MAX_LINE);
		end else begin
			eff_w = WID_W'(lw_q);
		end
		if (fh_q < ROWS_CFG_W'(2)) begin
			eff_h = HGT_W'(2);
		end else if (32'(fh_q) > MAX_ROWS) begin
			eff_h = HGT_W'(MAX_ROWS);
		end else begin
			eff_h = HGT_W'(fh_q);
		end
	end

	assign in_fire  = in_valid && in_ready;
	assign is_flush = (opcode == OP_FLUSH);

	always_comb begin
		wrap     = (WID_W'(col_q) >= eff_w) || (HGT_W'(row_q) >= eff_h);
		c0       = wrap ? '0 : col_q;
		r0       = wrap ? '0 : row_q;
		col_last = (WID_W'(c0) + WID_W'(1)) == eff_w;
		row_last = (HGT_W'(r0) + HGT_W'(1)) == eff_h;
		fl_ok    = pend_q && (WID_W'(fcnt_q) < eff_w);
		fl_last  = (WID_W'(fcnt_q) + WID_W'(1)) == eff_w;
		addr_a   = is_flush ? fcnt_q : c0;
		addr_b   = fcnt_q + COL_W'(1);
		fwd_a    = s1_valid_q && !s1_q.is_flush && (addr_a == c_s1);
		fwd_b    = s1_valid_q && !s1_q.is_flush && (addr_b == c_s1);

		ctl0          = '0;
		ctl0.is_flush = is_flush;
		ctl0.kind0    = KIND_MID;
		if (is_flush) begin
			ctl0.kind0   = KIND_FLUSH;
			ctl0.res_cnt = 2'd1;
			ctl0.left0   = (fcnt_q != '0);
			ctl0.right0  = !fl_last;
			ctl0.last0   = fl_last;
		end else if (c0 == '0) begin
			// row start closes the right edge of the row before last
			if (32'(r0) >= 2) begin
				ctl0.kind0   = KIND_EDGE_OLD;
				ctl0.res_cnt = 2'd1;
				ctl0.top0    = (32'(r0) >= 3);
			end
		end else if (32'(r0) >= 1) begin
			ctl0.kind0   = KIND_MID;
			ctl0.res_cnt = (col_last && row_last) ? 2'd2 : 2'd1;
			ctl0.top0    = (32'(r0) >= 2);
			ctl0.left0   = (32'(c0) >= 2);
			ctl0.top_new = (32'(eff_h) >= 3);
		end
		load_s1 = in_fire && (!is_flush || fl_ok);
	end

	always_comb begin
		out_space = !out_valid || out_ready;
		last_slot = (s1_q.res_cnt == 2'd2) ? slot_q : 1'b1;
		emit      = s1_valid_q && (s1_q.res_cnt != 2'd0) && out_space;
		s1_done   = s1_valid_q && ((s1_q.res_cnt == 2'd0) || (out_space && last_slot));
		in_ready  = !s1_valid_q || s1_done;
		mem_we    = s1_done && !s1_q.is_flush;
		cur_kind  = slot_q ? KIND_EDGE_NEW : s1_q.kind0;

		for (int i = 0; i < 3; i++) begin
			nxt_win[i][0] = win_q[i][1];
			nxt_win[i][1] = win_q[i][2];
		end
		nxt_win[0][2] = top_a_s1;
		nxt_win[1][2] = mid_a_s1;
		nxt_win[2][2] = pix_s1;

		avg_win  = '0;
		avg_mask = '0;
		case (cur_kind)
			KIND_EDGE_OLD: begin
				for (int i = 0; i < 3; i++) begin
					avg_win[i][0] = win_q[i][1];
					avg_win[i][1] = win_q[i][2];
				end
				avg_mask.row = {1'b1, 1'b1, s1_q.top0};
				avg_mask.col = 3'b011;
			end
			KIND_MID: begin
				avg_win      = nxt_win;
				avg_mask.row = {1'b1, 1'b1, s1_q.top0};
				avg_mask.col = {1'b1, 1'b1, s1_q.left0};
			end
			KIND_EDGE_NEW: begin
				for (int i = 0; i < 3; i++) begin
					avg_win[i][0] = nxt_win[i][1];
					avg_win[i][1] = nxt_win[i][2];
				end
				avg_mask.row = {1'b1, 1'b1, s1_q.top_new};
				avg_mask.col = 3'b011;
			end
			KIND_FLUSH: begin
				// last row: older store above, newer store in the centre
				avg_win[0][0] = fl_top_q;
				avg_win[0][1] = top_a_s1;
				avg_win[0][2] = top_b_s1;
				avg_win[1][0] = fl_mid_q;
				avg_win[1][1] = mid_a_s1;
				avg_win[1][2] = mid_b_s1;
				avg_mask.row  = 3'b011;
				avg_mask.col  = {s1_q.right0, 1'b1, s1_q.left0};
			end
			default: begin
			end
		endcase
		res_end = (cur_kind == KIND_FLUSH) && s1_q.last0;
	end

	bb3_avg u_avg (
		.win  (avg_win),
		.mask (avg_mask),
		.mean (mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q       <= LINE_WIDTH_RST;
			fh_q       <= FRAME_HEIGHT_RST;
			col_q      <= '0;
			row_q      <= '0;
			fcnt_q     <= '0;
			pend_q     <= 1'b0;
			s1_valid_q <= 1'b0;
			slot_q     <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_LINE_WIDTH:   lw_q <= cfg_data[LINE_CFG_W-1:0];
					REG_FRAME_HEIGHT: fh_q <= cfg_data[ROWS_CFG_W-1:0];
					default: begin
					end
				endcase
				col_q  <= '0;
				row_q  <= '0;
				fcnt_q <= '0;
				pend_q <= 1'b0;
			end else if (in_fire) begin
				if (is_flush) begin
					if (fl_ok) begin
						if (fl_last) begin
							fcnt_q <= '0;
							pend_q <= 1'b0;
						end else begin
							fcnt_q <= fcnt_q + COL_W'(1);
						end
					end
				end else begin
					// a pixel drops whatever of the last row is still pending
					fcnt_q <= '0;
					pend_q <= col_last && row_last;
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							row_q <= '0;
						end else begin
							row_q <= r0 + ROW_W'(1);
						end
					end else begin
						col_q <= c0 + COL_W'(1);
						row_q <= r0;
					end
				end
			end

			if (load_s1) begin
				s1_valid_q <= 1'b1;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_done) begin
				slot_q <= 1'b0;
			end else if (emit) begin
				slot_q <= 1'b1;
			end

			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (mem_we) begin
			win_q <= nxt_win;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			s1_q   <= ctl0;
			c_s1   <= c0;
			pix_s1 <= {in_red, in_green, in_blue};
		end
		if (s1_done && s1_q.is_flush) begin
			fl_top_q <= top_a_s1;
			fl_mid_q <= mid_a_s1;
		end
		if (emit) begin
			out_red   <= mean.red;
			out_green <= mean.green;
			out_blue  <= mean.blue;
			frame_end <= res_end;
		end
	end

	// line buffers: the column written by the item leaving is forwarded to a read of it
	always_ff @(posedge clk) begin
		if (mem_we) begin
			older_mem[c_s1] <= mid_a_s1;
			newer_mem[c_s1] <= pix_s1;
		end
		if (load_s1) begin
			top_a_s1 <= fwd_a ? mid_a_s1 : older_mem[addr_a];
			mid_a_s1 <= fwd_a ? pix_s1   : newer_mem[addr_a];
			top_b_s1 <= fwd_b ? mid_a_s1 : older_mem[addr_b];
			mid_b_s1 <= fwd_b ? pix_s1   : newer_mem[addr_b];
		end
	end

	a_pend_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !cfg_write && (opcode == OP_PIXEL) && col_last && row_last) |=> pend_q)
		else $error("last pixel of frame did not arm the flush");

	a_slot_two: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q |-> (s1_valid_q && (s1_q.res_cnt == 2'd2)))
		else $error("second result slot without a two-result item");

	a_accept_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s1_valid_q) |-> s1_done)
		else $error("item accepted over an unfinished item");

	a_pend_home: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> ((col_q == '0) && (row_q == '0)))
		else $error("flush pending away from frame start");

endmodule

@@ verif/box_blur_3x3_edge_aware_unit_tb.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_unit_tb: self-checking bench for the 3x3 box blur
// A short scripted part (clamped sizes, flat frames, rounding at one half,
// flush with nothing pending, a pixel cutting a flush short) is followed by
// random frames of many sizes, one of them at the widest row. A local line
// buffer and window model predicts every result, which is checked in order
// against the output channel while both sides stall at random.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_unit_tb;
	import bb3_pkg::*;

	localparam int MAX_LINE      = 1024;
	localparam int MAX_ROWS      = 4096;
	localparam int RANDOM_ITEMS  = 1450;
	localparam int SETTLE_CYCLES = 16;
	localparam int SCRIPT_LEN    = 23;

	typedef struct packed {
		rgb_t px;
		logic last;
	} blur_res_t;

	typedef enum logic {
		STEP_REG,
		STEP_ITEM
	} step_kind_t;

	typedef struct {
		step_kind_t kind;
		reg_idx_t   idx;
		int         value;
		op_t        op;
		rgb_t       px;
		bit         pinned;
		rgb_t       want;
	} step_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_write = 1'b0;
	reg_idx_t              cfg_index = REG_LINE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	op_t                   opcode    = OP_PIXEL;
	logic [7:0]            in_red    = '0;
	logic [7:0]            in_green  = '0;
	logic [7:0]            in_blue   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            out_red;
	logic [7:0]            out_green;
	logic [7:0]            out_blue;
	logic                  frame_end;

	// fixed expectation travelling with a scripted item
	bit   pin_on = 1'b0;
	rgb_t pin_px = '0;

	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	int fail_count = 0;
	int random_items = 0;

	// blur model state
	logic [LINE_CFG_W-1:0] cfg_line = LINE_WIDTH_RST;
	logic [ROWS_CFG_W-1:0] cfg_rows = FRAME_HEIGHT_RST;
	rgb_t older_line [MAX_LINE] = '{default: '0};
	rgb_t newer_line [MAX_LINE] = '{default: '0};
	win_t blur_win = '0;
	int   col_pos = 0;
	int   row_pos = 0;
	int   flush_col = 0;
	bit   flush_armed = 1'b0;

	blur_res_t expected_q [$];

	step_t script [SCRIPT_LEN] = '{
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_FLUSH, 24'h5A5A5A, 1'b0, 24'h0},
		'{STEP_REG,  REG_LINE_WIDTH,   0,    OP_PIXEL, 24'h0,      1'b0, 24'h0},
		'{STEP_REG,  REG_FRAME_HEIGHT, 1,    OP_PIXEL, 24'h0,      1'b0, 24'h0},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'hFFFFFF, 1'b0, 24'h0},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'hFFFFFF, 1'b0, 24'h0},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'hFFFFFF, 1'b0, 24'h0},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_FLUSH, 24'h123456, 1'b1, 24'hFFFFFF},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_FLUSH, 24'hEDCBA9, 1'b1, 24'hFFFFFF},
		'{STEP_REG,  REG_LINE_WIDTH,   2,    OP_PIXEL, 24'h0,      1'b0, 24'h0},
		'{STEP_REG,  REG_FRAME_HEIGHT, 2,    OP_PIXEL, 24'h0,      1'b0, 24'h0},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'h000000, 1'b0, 24'h0},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'h000000, 1'b0, 24'h0},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'h000000, 1'b0, 24'h0},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'h000000, 1'b1, 24'h000000},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_FLUSH, 24'hFFFFFF, 1'b1, 24'h000000},
		// pixel while one flush item is still owed: the rest of the row is dropped
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'h00FF00, 1'b0, 24'h0},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'h01FE00, 1'b0, 24'h0},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'h01FE00, 1'b0, 24'h0},
		// means of 0.5 and 254.5 round up
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_PIXEL, 24'h00FF00, 1'b1, 24'h01FF00},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_FLUSH, 24'h0,      1'b1, 24'h01FF00},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_FLUSH, 24'h0,      1'b1, 24'h01FF00},
		'{STEP_ITEM, REG_LINE_WIDTH,   0,    OP_FLUSH, 24'h0,      1'b0, 24'h0}
	};

	box_blur_3x3_edge_aware_unit #(
		.MAX_LINE(MAX_LINE),
		.MAX_ROWS(MAX_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.in_red(in_red),
		.in_green(in_green),
		.in_blue(in_blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.frame_end(frame_end)
	);

	always #2 clk = ~clk;

	function automatic int line_px();
		int w = cfg_line;
		if (w < 2) w = 2;
		if (w > MAX_LINE) w = MAX_LINE;
		return w;
	endfunction

	function automatic int frame_rows();
		int h = cfg_rows;
		if (h < 2) h = 2;
		if (h > MAX_ROWS) h = MAX_ROWS;
		return h;
	endfunction

	function automatic void blur_config(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		if (idx == REG_LINE_WIDTH) cfg_line = val[LINE_CFG_W-1:0];
		else cfg_rows = val[ROWS_CFG_W-1:0];
		col_pos = 0;
		row_pos = 0;
		flush_col = 0;
		flush_armed = 1'b0;
	endfunction

	// rounded half up: (2*sum + n) / (2*n) over the in-frame pixels
	function automatic rgb_t blur_mean(win_t px, bit top, bit bot, bit left, bit right);
		int sr = 0;
		int sg = 0;
		int sb = 0;
		int n = 0;
		rgb_t m;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if ((i == 0 && !top) || (i == 2 && !bot) || (j == 0 && !left) ||
				    (j == 2 && !right))
					continue;
				sr += px[i][j].red;
				sg += px[i][j].green;
				sb += px[i][j].blue;
				n++;
			end
		end
		m.red   = 8'((2 * sr + n) / (2 * n));
		m.green = 8'((2 * sg + n) / (2 * n));
		m.blue  = 8'((2 * sb + n) / (2 * n));
		return m;
	endfunction

	// last pixel of a row: centre sits in window column 2
	function automatic rgb_t right_col_mean(bit top);
		win_t t;
		for (int i = 0; i < 3; i++) begin
			t[i][0] = blur_win[i][1];
			t[i][1] = blur_win[i][2];
			t[i][2] = '0;
		end
		return blur_mean(t, top, 1'b1, 1'b1, 1'b0);
	endfunction

	function automatic void push_result(rgb_t px, logic last);
		blur_res_t res;
		res.px = pin_on ? pin_px : px;
		res.last = last;
		expected_q.push_back(res);
	endfunction

	function automatic void blur_predict(op_t op, rgb_t pix);
		int w;
		int h;
		int c;
		int r;
		int k;
		win_t t;
		rgb_t up2;
		rgb_t up1;
		w = line_px();
		h = frame_rows();
		if (op == OP_FLUSH) begin
			k = flush_col;
			if (!flush_armed || k >= w) return;
			for (int j = 0; j < 3; j++) begin
				t[0][j] = '0;
				t[1][j] = '0;
				t[2][j] = '0;
				if (k + j >= 1 && k + j - 1 < w) begin
					t[0][j] = older_line[k + j - 1];
					t[1][j] = newer_line[k + j - 1];
				end
			end
			push_result(blur_mean(t, 1'b1, 1'b0, k != 0, k + 1 < w), k + 1 == w);
			flush_col = k + 1;
			if (flush_col >= w) begin
				flush_col = 0;
				flush_armed = 1'b0;
			end
			return;
		end
		if (flush_armed) begin
			flush_armed = 1'b0;
			flush_col = 0;
		end
		c = col_pos;
		r = row_pos;
		if (c >= w || r >= h) begin
			c = 0;
			r = 0;
		end
		if (c == 0 && r >= 2) push_result(right_col_mean(r - 2 > 0), 1'b0);
		up2 = older_line[c];
		up1 = newer_line[c];
		for (int i = 0; i < 3; i++) begin
			blur_win[i][0] = blur_win[i][1];
			blur_win[i][1] = blur_win[i][2];
		end
		blur_win[0][2] = up2;
		blur_win[1][2] = up1;
		blur_win[2][2] = pix;
		older_line[c] = up1;
		newer_line[c] = pix;
		if (c >= 1 && r >= 1) push_result(blur_mean(blur_win, r - 1 > 0, 1'b1, c >= 2, 1'b1), 1'b0);
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				push_result(right_col_mean(h - 2 > 0), 1'b0);
				r = 0;
				flush_armed = 1'b1;
				flush_col = 0;
			end
		end
		col_pos = c;
		row_pos = r;
	endfunction

	function automatic void check_result();
		blur_res_t want;
		if (expected_q.size() == 0) begin
			if (fail_count < 10)
				$display("unexpected result: rgb %h %h %h frame_end %b",
					out_red, out_green, out_blue, frame_end);
			fail_count++;
			return;
		end
		want = expected_q.pop_front();
		if (out_red !== want.px.red || out_green !== want.px.green ||
		    out_blue !== want.px.blue || frame_end !== want.last) begin
			if (fail_count < 10)
				$display("mismatch: expected rgb %h %h %h frame_end %b, got %h %h %h %b",
					want.px.red, want.px.green, want.px.blue, want.last,
					out_red, out_green, out_blue, frame_end);
			fail_count++;
		end
	endfunction

	// predict before checking, so a result in the accepting cycle still finds its entry
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) blur_predict(op_t'(opcode), {in_red, in_green, in_blue});
			if (out_valid && out_ready) check_result();
		end
	end

	task automatic send_item(op_t op, rgb_t px, bit pinned, rgb_t want);
		int gap;
		bit pause;
		gap = src_idle ? $urandom_range(0, 13) : 0;
		pause = src_idle && $urandom_range(0, 99) == 0;
		// a pause always drops valid before the next item
		if (pause && gap == 0) gap = 1;
		if (gap != 0) in_valid <= 1'b0;
		if (pause) begin
			while (expected_q.size() != 0) @(posedge clk);
		end
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		opcode   <= op;
		in_red   <= px.red;
		in_green <= px.green;
		in_blue  <= px.blue;
		pin_on   <= pinned;
		pin_px   <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		// rows without results may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		blur_config(idx, val);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic rgb_t rand_pixel(int tone);
		logic [31:0] raw;
		rgb_t p;
		raw = $urandom;
		case (tone)
			4: begin
				p.red   = {8{raw[0]}};
				p.green = {8{raw[1]}};
				p.blue  = {8{raw[2]}};
			end
			5: begin
				p.red   = 8'($urandom_range(250, 255));
				p.green = 8'($urandom_range(250, 255));
				p.blue  = 8'($urandom_range(250, 255));
			end
			default: p = raw[23:0];
		endcase
		return p;
	endfunction

	task automatic run_phase(bit wide);
		int pick;
		int line_val;
		int rows_val;
		int w;
		int h;
		int frames;
		int total;
		int tone;
		int tail;
		settle();
		pick = $urandom_range(0, 9);
		if (wide) line_val = $urandom_range(0, 1) ? 1024 : 2047;
		else if (pick < 7) line_val = $urandom_range(2, 8);
		else if (pick < 9) line_val = $urandom_range(9, 40);
		else line_val = $urandom_range(0, 1);
		pick = $urandom_range(0, 19);
		if (wide) rows_val = $urandom_range(2, 3);
		else if (pick < 14) rows_val = $urandom_range(2, 5);
		else if (pick < 17) rows_val = $urandom_range(0, 1);
		else if (pick == 17) rows_val = 8191;
		else if (pick == 18) rows_val = 4096;
		else rows_val = $urandom_range(7, 8190);
		if ($urandom_range(0, 1)) begin
			write_reg(REG_LINE_WIDTH, CFG_DATA_W'(line_val));
			write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(rows_val));
		end else begin
			write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(rows_val));
			write_reg(REG_LINE_WIDTH, CFG_DATA_W'(line_val));
		end
		w = line_px();
		h = frame_rows();
		src_idle = $urandom_range(0, 3) != 0;
		snk_idle = $urandom_range(0, 3) != 0;
		frames = wide ? 1 : $urandom_range(1, 3);
		for (int f = 0; f < frames; f++) begin
			tone = $urandom_range(0, 5);
			if (wide) total = w + $urandom_range(1, 40);
			else if (h > 6) total = w * $urandom_range(2, 3) + $urandom_range(0, w - 1);
			else if ($urandom_range(0, 9) == 0) total = $urandom_range(1, w * h - 1);
			else total = w * h;
			for (int p = 0; p < total; p++) begin
				// stray flush item, mostly ignored
				if ($urandom_range(0, 24) == 0) begin
					send_item(OP_FLUSH, rand_pixel(0), 1'b0, '0);
					random_items++;
				end
				send_item(OP_PIXEL, rand_pixel(tone), 1'b0, '0);
				random_items++;
			end
			// cut frame: the next register write restarts it
			if (total != w * h) break;
			pick = $urandom_range(0, 7);
			if (pick == 0) tail = 0;
			else if (pick == 1) tail = $urandom_range(1, w - 1);
			else tail = w + $urandom_range(0, 2);
			for (int k = 0; k < tail; k++) begin
				send_item(OP_FLUSH, rand_pixel(0), 1'b0, '0);
				random_items++;
			end
		end
	endtask

	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = snk_idle ? $urandom_range(0, 13) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		bit wide_done;
		wide_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i]) begin
			if (script[i].kind == STEP_REG) begin
				settle();
				write_reg(script[i].idx, CFG_DATA_W'(script[i].value));
			end else begin
				send_item(script[i].op, script[i].px, script[i].pinned, script[i].want);
			end
		end
		while (random_items < RANDOM_ITEMS) begin
			if (!wide_done && random_items >= 300) begin
				run_phase(1'b1);
				wide_done = 1'b1;
			end else begin
				run_phase(1'b0);
			end
		end
		settle();
		if (fail_count == 0 && expected_q.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/bb3_pkg.sv
rtl/bb3_avg.sv
rtl/box_blur_3x3_edge_aware_unit.sv
verif/box_blur_3x3_edge_aware_unit_tb.sv
